FILE: rtl/adam_sgd_weight_update_macros.svh
// Assertion macros for the weight update block
`ifndef ADAM_SGD_WEIGHT_UPDATE_MACROS_SVH
`define ADAM_SGD_WEIGHT_UPDATE_MACROS_SVH

// overlapping implication or plain property, sampled on clock, off in reset
`define ASGD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition now implies consequence in the next cycle
`define ASGD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/asgd_pkg.sv
// Types and constants for the Adam / gradient descent weight update
`timescale 1ns / 1ps

package asgd_pkg;

   typedef struct packed {
      logic [11:0]        index;
      logic signed [31:0] weight;
      logic signed [31:0] gradient;
      logic               has_gradient;
      logic               pass_end;
   } req_type;

   typedef struct packed {
      logic [11:0]        out_index;
      logic signed [31:0] new_weight;
      logic               saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_GD   = 2'd1,
      MODE_ADAM = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE       = 3'd0,
      CSR_DECAY_EN   = 3'd1,
      CSR_DECAY_RATE = 3'd2,
      CSR_STEP       = 3'd3,
      CSR_BETA1      = 3'd4,
      CSR_BETA2      = 3'd5,
      CSR_STAB       = 3'd6
   } csr_idx_type;

   // common per-beat pipeline payload
   typedef struct packed {
      logic               vld;
      logic [11:0]        idx;
      logic signed [31:0] w;
      logic signed [31:0] m;
      logic               sat;
      logic               act;
      logic               ad;
   } pl_type;

   localparam logic [24:0] ONE_Q24   = 25'd16777216;
   localparam logic [23:0] RST_STEP  = 24'd16777;
   localparam logic [23:0] RST_BETA1 = 24'd15099494;
   localparam logic [23:0] RST_BETA2 = 24'd16760439;
   localparam logic [15:0] RST_STAB  = 16'd7;
   localparam int          SQ_STEPS  = 32;
   localparam int          DV_STEPS  = 33;
   // remainder of 2^47 after the quotient bits that are always zero
   localparam logic [32:0] DV_REM0   = 33'd16384;

endpackage

FILE: rtl/adam_sgd_weight_update.sv
// Adam / gradient descent weight update pipeline, one element per beat
//
//   channel | ports                               | direction
//   req     | req_valid, req_ready, req_data      | in,  valid/ready
//   rsp     | rsp_valid, rsp_ready, rsp_data      | out, valid/ready
//   csr     | csr_we, csr_index, csr_wdata        | in,  write only
//
// One beat is accepted per cycle unless a stall, the clear or a hazard holds the input; each
// beat passes through the 32-step square root and 33-step reciprocal division pipelines.
// After reset the moment memory is zeroed slot by slot; req_ready is low meanwhile.
// A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
// An Adam beat after the first pass whose moment slot is still being updated in the first
// five stages waits at the input until that write has landed.
`timescale 1ns / 1ps
`include "adam_sgd_weight_update_macros.svh"

module adam_sgd_weight_update
   import asgd_pkg::*;
#(
   parameter int DEPTH       = 4096,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int EFF    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic signed [65:0] SHI = (66'sd1 <<< (EFF - 1)) - 66'sd1;
   localparam logic signed [65:0] SLO = -SHI - 66'sd1;
   localparam logic [65:0]        UHI = (66'd1 << EFF) - 66'd1;

   function automatic logic [32:0] sat_s(input logic signed [65:0] x);
      logic [32:0] r;
      if (x > SHI) r = {1'b1, SHI[31:0]};
      else if (x < SLO) r = {1'b1, SLO[31:0]};
      else r = {1'b0, x[31:0]};
      return r;
   endfunction

   function automatic logic [32:0] sat_u(input logic [65:0] x);
      logic [32:0] r;
      if (x > UHI) r = {1'b1, UHI[31:0]};
      else r = {1'b0, x[31:0]};
      return r;
   endfunction

   // configuration
   logic [1:0]  mode_ff;
   logic        dec_en_ff;
   logic [23:0] dec_rate_ff, step_ff, beta1_ff, beta2_ff;
   logic [15:0] stab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NONE;
         dec_en_ff   <= 1'b0;
         dec_rate_ff <= '0;
         step_ff     <= RST_STEP;
         beta1_ff    <= RST_BETA1;
         beta2_ff    <= RST_BETA2;
         stab_ff     <= RST_STAB;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff     <= csr_wdata[1:0];
            CSR_DECAY_EN:   dec_en_ff   <= csr_wdata[0];
            CSR_DECAY_RATE: dec_rate_ff <= csr_wdata;
            CSR_STEP:       step_ff     <= csr_wdata;
            CSR_BETA1:      beta1_ff    <= csr_wdata;
            CSR_BETA2:      beta2_ff    <= csr_wdata;
            CSR_STAB:       stab_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   pl_type o_ff;
   logic   adv, acc, haz, req_rd, act_in, pff_ff, clr_ff;
   logic [SLOT_W-1:0] clr_cnt_ff, req_slot;

   assign adv       = !o_ff.vld || rsp_ready;
   assign act_in    = (mode_ff == MODE_GD) || (mode_ff == MODE_ADAM);
   assign req_rd    = (mode_ff == MODE_ADAM) && req_data.has_gradient && pff_ff;
   assign req_ready = adv && !clr_ff && !haz;
   assign acc       = req_valid && req_ready;

   generate
      if (DEPTH >= 4096) begin : g_slot_full
         assign req_slot = SLOT_W'(req_data.index);
      end else begin : g_slot_mod
         localparam logic [24:0] RECIP = 25'((1 << 24) / DEPTH + 1);
         logic [36:0] prod;
         logic [11:0] quo;
         logic [23:0] back;
         assign prod     = 37'(req_data.index) * 37'(RECIP);
         assign quo      = prod[35:24];
         assign back     = 24'(quo) * 24'(DEPTH);
         assign req_slot = SLOT_W'(24'(req_data.index) - back);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         pff_ff     <= 1'b0;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         if (acc && act_in && req_data.pass_end) pff_ff <= 1'b1;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_W'(DEPTH - 1)) clr_ff <= 1'b0;
         end
      end
   end

   // moment memory: {m, v}
   logic [63:0]       mem [DEPTH];
   logic [63:0]       rd_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   logic [63:0]       mem_wd;

   // stage a
   pl_type             pa_in, pa_ff;
   logic signed [31:0] a_g_ff;
   logic               a_gd_ff, a_rdm_ff;
   logic [SLOT_W-1:0]  a_slot_ff;

   always_comb begin
      pa_in.vld = acc;
      pa_in.idx = req_data.index;
      pa_in.w   = req_data.weight;
      pa_in.m   = '0;
      pa_in.sat = 1'b0;
      pa_in.act = act_in;
      pa_in.ad  = (mode_ff == MODE_ADAM) && req_data.has_gradient;
   end

   always_ff @(posedge clock) begin
      if (reset) pa_ff.vld <= 1'b0;
      else if (adv) pa_ff <= pa_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_g_ff    <= req_data.gradient;
         a_gd_ff   <= (mode_ff == MODE_GD) && req_data.has_gradient;
         a_rdm_ff  <= pff_ff;
         a_slot_ff <= req_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (adv) rd_ff <= mem[req_slot];
   end

   // stage b: products
   pl_type             pb_ff;
   logic [31:0]        a_gmag;
   logic [24:0]        one_b1, one_b2;
   logic signed [56:0] b_pm1_ff;
   logic signed [57:0] b_pm2_ff;
   logic [63:0]        b_pg_ff;
   logic [55:0]        b_pgd_ff;
   logic signed [31:0] b_g_ff;
   logic [31:0]        b_vo_ff;
   logic               b_gd_ff, b_rdm_ff;
   logic [SLOT_W-1:0]  b_slot_ff;

   assign a_gmag = a_g_ff[31] ? 32'(-a_g_ff) : 32'(a_g_ff);
   assign one_b1 = ONE_Q24 - {1'b0, beta1_ff};
   assign one_b2 = ONE_Q24 - {1'b0, beta2_ff};

   always_ff @(posedge clock) begin
      if (reset) pb_ff.vld <= 1'b0;
      else if (adv) pb_ff <= pa_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_pm1_ff  <= $signed(rd_ff[63:32]) * $signed({1'b0, beta1_ff});
         b_pm2_ff  <= a_g_ff * $signed({1'b0, one_b1});
         b_pg_ff   <= 64'(a_gmag) * 64'(a_gmag);
         b_pgd_ff  <= 56'(a_gmag) * 56'(step_ff);
         b_g_ff    <= a_g_ff;
         b_vo_ff   <= rd_ff[31:0];
         b_gd_ff   <= a_gd_ff;
         b_rdm_ff  <= a_rdm_ff;
         b_slot_ff <= a_slot_ff;
      end
   end

   // stage c: new m, g squared, plain descent step
   pl_type             pc_in, pc_ff;
   logic signed [58:0] c_sum;
   logic [58:0]        c_mag, c_mrs;
   logic signed [65:0] c_mb, c_wgd;
   logic [32:0]        c_msat, c_gsat, c_msel, c_g2sat, c_wsat;
   logic [64:0]        c_g2s;
   logic [56:0]        c_dqs;
   logic [31:0]        c_g2_ff, c_vo_ff;
   logic               c_rdm_ff;
   logic [SLOT_W-1:0]  c_slot_ff;

   always_comb begin
      c_sum   = 59'(b_pm1_ff) + 59'(b_pm2_ff);
      c_mag   = c_sum[58] ? 59'(-c_sum) : 59'(c_sum);
      c_mrs   = c_mag + 59'd8388608;
      c_mb    = c_sum[58] ? -$signed(66'(c_mrs[58:24])) : $signed(66'(c_mrs[58:24]));
      c_msat  = sat_s(c_mb);
      c_gsat  = sat_s(66'(b_g_ff));
      c_msel  = b_rdm_ff ? c_msat : c_gsat;
      c_g2s   = 65'(b_pg_ff) + 65'd32768;
      c_g2sat = sat_u(66'(c_g2s[64:16]));
      c_dqs   = 57'(b_pgd_ff) + 57'd8388608;
      c_wgd   = b_g_ff[31] ? 66'(pb_ff.w) + $signed(66'(c_dqs[56:24]))
                           : 66'(pb_ff.w) - $signed(66'(c_dqs[56:24]));
      c_wsat  = sat_s(c_wgd);
      pc_in   = pb_ff;
      pc_in.m = c_msel[31:0];
      if (b_gd_ff) pc_in.w = c_wsat[31:0];
      pc_in.sat = (b_gd_ff && c_wsat[32]) || (pb_ff.ad && (c_g2sat[32] || c_msel[32]));
   end

   always_ff @(posedge clock) begin
      if (reset) pc_ff.vld <= 1'b0;
      else if (adv) pc_ff <= pc_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_g2_ff   <= c_g2sat[31:0];
         c_vo_ff   <= b_vo_ff;
         c_rdm_ff  <= b_rdm_ff;
         c_slot_ff <= b_slot_ff;
      end
   end

   // stage d: second moment products
   pl_type            pd_ff;
   logic [55:0]       d_pv1_ff;
   logic [56:0]       d_pv2_ff;
   logic [31:0]       d_g2_ff;
   logic              d_rdm_ff;
   logic [SLOT_W-1:0] d_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) pd_ff.vld <= 1'b0;
      else if (adv) pd_ff <= pc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_pv1_ff  <= 56'(c_vo_ff) * 56'(beta2_ff);
         d_pv2_ff  <= 57'(c_g2_ff) * 57'(one_b2);
         d_g2_ff   <= c_g2_ff;
         d_rdm_ff  <= c_rdm_ff;
         d_slot_ff <= c_slot_ff;
      end
   end

   // stage e: new v; moments written back as this stage moves on
   pl_type            pe_in, pe_ff;
   logic [57:0]       e_vs;
   logic [32:0]       e_vsat;
   logic [31:0]       e_v_ff;
   logic [SLOT_W-1:0] e_slot_ff;

   always_comb begin
      e_vs   = 58'(d_pv1_ff) + 58'(d_pv2_ff) + 58'd8388608;
      e_vsat = sat_u(66'(e_vs[57:24]));
      pe_in  = pd_ff;
      pe_in.sat = pd_ff.sat || (pd_ff.ad && d_rdm_ff && e_vsat[32]);
   end

   always_ff @(posedge clock) begin
      if (reset) pe_ff.vld <= 1'b0;
      else if (adv) pe_ff <= pe_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_v_ff    <= d_rdm_ff ? e_vsat[31:0] : d_g2_ff;
         e_slot_ff <= d_slot_ff;
      end
   end

   assign mem_we = clr_ff || (pe_ff.vld && pe_ff.ad && adv);
   assign mem_wa = clr_ff ? clr_cnt_ff : e_slot_ff;
   assign mem_wd = clr_ff ? 64'd0 : {pe_ff.m, e_v_ff};

   assign haz = req_rd && (
      (pa_ff.vld && pa_ff.ad && (a_slot_ff == req_slot)) ||
      (pb_ff.vld && pb_ff.ad && (b_slot_ff == req_slot)) ||
      (pc_ff.vld && pc_ff.ad && (c_slot_ff == req_slot)) ||
      (pd_ff.vld && pd_ff.ad && (d_slot_ff == req_slot)) ||
      (pe_ff.vld && pe_ff.ad && (e_slot_ff == req_slot)));

   // stage f: v + eps
   pl_type      pf_in, pf_ff;
   logic [32:0] f_s_in, f_s_ff;

   always_comb begin
      f_s_in = 33'(e_v_ff) + 33'(stab_ff);
      pf_in  = pe_ff;
      if (f_s_in == 33'd0) begin
         f_s_in    = 33'd1;
         pf_in.sat = pe_ff.sat || pe_ff.ad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pf_ff.vld <= 1'b0;
      else if (adv) pf_ff <= pf_in;
   end

   always_ff @(posedge clock) begin
      if (adv) f_s_ff <= f_s_in;
   end

   // square root of s * 2^30, one result bit per stage
   pl_type      sq_pl_ff   [1:SQ_STEPS];
   logic [34:0] sq_rem_ff  [1:SQ_STEPS];
   logic [31:0] sq_root_ff [1:SQ_STEPS];
   logic [32:0] sq_s_ff    [1:SQ_STEPS];

   generate
      for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
         logic [34:0] rp, rt, tr;
         logic [31:0] qp;
         logic [32:0] sp;
         logic [63:0] x;
         pl_type      pp;
         if (k == 1) begin : g_head
            assign rp = '0;
            assign qp = '0;
            assign sp = f_s_ff;
            assign pp = pf_ff;
         end else begin : g_tail
            assign rp = sq_rem_ff[k-1];
            assign qp = sq_root_ff[k-1];
            assign sp = sq_s_ff[k-1];
            assign pp = sq_pl_ff[k-1];
         end
         assign x  = {1'b0, sp, 30'b0};
         assign rt = {rp[32:0], x[2*(SQ_STEPS-k)+1 -: 2]};
         assign tr = {1'b0, qp, 2'b01};
         always_ff @(posedge clock) begin
            if (reset) sq_pl_ff[k].vld <= 1'b0;
            else if (adv) sq_pl_ff[k] <= pp;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_s_ff[k] <= sp;
               if (rt >= tr) begin
                  sq_rem_ff[k]  <= rt - tr;
                  sq_root_ff[k] <= {qp[30:0], 1'b1};
               end else begin
                  sq_rem_ff[k]  <= rt;
                  sq_root_ff[k] <= {qp[30:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // 2^47 / root, one quotient bit per stage
   pl_type      dv_pl_ff  [1:DV_STEPS];
   logic [32:0] dv_rem_ff [1:DV_STEPS];
   logic [32:0] dv_q_ff   [1:DV_STEPS];
   logic [31:0] dv_d_ff   [1:DV_STEPS];

   generate
      for (genvar j = 1; j <= DV_STEPS; j++) begin : g_dv
         logic [32:0] pr, pq;
         logic [31:0] pd;
         logic [33:0] t;
         logic        ge;
         pl_type      pp;
         if (j == 1) begin : g_head
            assign pr = DV_REM0;
            assign pq = '0;
            assign pd = sq_root_ff[SQ_STEPS];
            assign pp = sq_pl_ff[SQ_STEPS];
         end else begin : g_tail
            assign pr = dv_rem_ff[j-1];
            assign pq = dv_q_ff[j-1];
            assign pd = dv_d_ff[j-1];
            assign pp = dv_pl_ff[j-1];
         end
         assign t  = {pr, 1'b0};
         assign ge = t >= {2'b0, pd};
         always_ff @(posedge clock) begin
            if (reset) dv_pl_ff[j].vld <= 1'b0;
            else if (adv) dv_pl_ff[j] <= pp;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j] <= ge ? 33'(t - {2'b0, pd}) : t[32:0];
               dv_q_ff[j]   <= {pq[31:0], ge};
               dv_d_ff[j]   <= pd;
            end
         end
      end
   endgenerate

   // |m| * rsqrt, then * step, then apply, then decay
   pl_type      p1_ff, p2_ff, p3_ff, p4_in, p4_ff, p5_ff, o_in;
   logic [31:0] p1_mmag, p4_wmag;
   logic [64:0] p1_pm_ff, p2_ds;
   logic [40:0] p2_d_ff;
   logic [64:0] p3_pd_ff, p4_ds;
   logic signed [65:0] p4_wn, o_wn;
   logic [32:0] p4_sat, o_sat;
   logic [55:0] p5_pw_ff;
   logic [56:0] o_ds;

   assign p1_mmag = dv_pl_ff[DV_STEPS].m[31] ? 32'(-dv_pl_ff[DV_STEPS].m)
                                             : 32'(dv_pl_ff[DV_STEPS].m);
   assign p2_ds   = p1_pm_ff + 65'd8388608;
   assign p4_ds   = p3_pd_ff + 65'd8388608;
   assign p4_wmag = p4_ff.w[31] ? 32'(-p4_ff.w) : 32'(p4_ff.w);

   always_comb begin
      p4_wn = p3_ff.m[31] ? 66'(p3_ff.w) + $signed(66'(p4_ds[64:24]))
                          : 66'(p3_ff.w) - $signed(66'(p4_ds[64:24]));
      p4_sat = sat_s(p4_wn);
      p4_in  = p3_ff;
      if (p3_ff.ad) begin
         p4_in.w   = p4_sat[31:0];
         p4_in.sat = p3_ff.sat || p4_sat[32];
      end
   end

   always_comb begin
      o_ds = 57'(p5_pw_ff) + 57'd8388608;
      o_wn = p5_ff.w[31] ? 66'(p5_ff.w) + $signed(66'(o_ds[56:24]))
                         : 66'(p5_ff.w) - $signed(66'(o_ds[56:24]));
      o_sat = sat_s(o_wn);
      o_in  = p5_ff;
      if (p5_ff.act && dec_en_ff) begin
         o_in.w   = o_sat[31:0];
         o_in.sat = p5_ff.sat || o_sat[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.vld <= 1'b0;
         p2_ff.vld <= 1'b0;
         p3_ff.vld <= 1'b0;
         p4_ff.vld <= 1'b0;
         p5_ff.vld <= 1'b0;
         o_ff.vld  <= 1'b0;
      end else if (adv) begin
         p1_ff <= dv_pl_ff[DV_STEPS];
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p4_in;
         p5_ff <= p4_ff;
         o_ff  <= o_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_pm_ff <= 65'(p1_mmag) * 65'(dv_q_ff[DV_STEPS]);
         p2_d_ff  <= p2_ds[64:24];
         p3_pd_ff <= 65'(p2_d_ff) * 65'(step_ff);
         p5_pw_ff <= 56'(p4_wmag) * 56'(dec_rate_ff);
      end
   end

   assign rsp_valid = o_ff.vld;

   always_comb begin
      rsp_data.out_index  = o_ff.idx;
      rsp_data.new_weight = o_ff.w;
      rsp_data.saturated  = o_ff.sat;
   end

   `ASGD_ASSERT(a_no_acc_clr, (req_valid && req_ready) |-> !clr_ff, "beat taken during clear")
   `ASGD_ASSERT(a_wr_excl, clr_ff |-> !(pe_ff.vld && pe_ff.ad), "moment write during clear")
   `ASGD_ASSERT_NEXT(a_pff_sticky, pff_ff, pff_ff, "first-pass flag fell")
   `ASGD_ASSERT_NEXT(a_stall_hold, !adv, $stable(pa_ff.vld) && $stable(o_ff.vld), "pipeline moved in stall")

endmodule

FILE: verif/testbench.sv
// Testbench for the Adam / gradient descent weight update block
`timescale 1ns / 1ps

module testbench;
   import asgd_pkg::*;

   localparam logic [2:0] CSR_SPARE  = 3'd7;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      bit          is_csr;
      logic [2:0]  csr_sel;
      logic [23:0] csr_val;
      req_type     beat;
      bit          fixed;
      rsp_type     want;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // shadow registers and moment memories
   logic [1:0]  cur_mode;
   bit          cur_decay_en;
   logic [23:0] cur_decay, cur_step, cur_beta1, cur_beta2;
   logic [15:0] cur_stab;
   bit [31:0]   m_mem [4096];
   bit [31:0]   v_mem [4096];
   bit          past_first;

   rsp_type      pending_q[$];
   step_row_type rows[$];
   int           errors = 0;
   bit           quiet = 0;
   bit           hold_req = 0;

   adam_sgd_weight_update dut (.*);

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("adam_sgd_weight_update verification failed");
      $finish;
   end

   task automatic report(string what, logic [63:0] got, logic [63:0] want_v);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want_v, $realtime);
      errors++;
   endtask

   function automatic void add_csr(logic [2:0] sel, logic [23:0] val);
      step_row_type r;
      r.is_csr  = 1'b1;
      r.csr_sel = sel;
      r.csr_val = val;
      r.beat    = '0;
      r.fixed   = 1'b0;
      r.want    = '0;
      rows.insert(rows.size(), r);
   endfunction

   function automatic void add_beat(req_type b, bit fixed, rsp_type want);
      step_row_type r;
      r.is_csr  = 1'b0;
      r.csr_sel = 3'd0;
      r.csr_val = 24'd0;
      r.beat    = b;
      r.fixed   = fixed;
      r.want    = want;
      rows.insert(rows.size(), r);
   endfunction

   function automatic longint sat_s(longint x, inout bit f);
      if (x > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
      if (x < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
      return x;
   endfunction

   function automatic longint unsigned sat_u(longint unsigned x, inout bit f);
      if (x > 64'hFFFF_FFFF) begin f = 1; return 64'hFFFF_FFFF; end
      return x;
   endfunction

   function automatic longint unsigned rnd_shift(longint unsigned mag, int sh);
      return (mag + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic longint scale_signed(longint a, longint unsigned f, int sh);
      longint unsigned mag, r;
      mag = a < 0 ? longint'(-a) : a;
      r = rnd_shift(mag * f, sh);
      return a < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x -= res + bt;
            res = (res >> 1) + bt;
         end else res >>= 1;
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type update_weight(req_type it);
      longint w, g, m, mo, prod;
      longint unsigned gm, g2, v, vo, s, q, r, d, q24;
      bit sat;
      rsp_type o;
      w = it.weight;
      g = it.gradient;
      sat = 0;
      q24 = ONE_Q24;
      if (cur_mode == MODE_GD || cur_mode == MODE_ADAM) begin
         if (it.has_gradient && cur_mode == MODE_GD) begin
            w = sat_s(w - scale_signed(g, cur_step, 24), sat);
         end else if (it.has_gradient) begin
            gm = g < 0 ? longint'(-g) : g;
            g2 = sat_u(rnd_shift(gm * gm, 16), sat);
            if (!past_first) begin
               m = sat_s(g, sat);
               v = g2;
            end else begin
               mo = longint'(signed'(m_mem[it.index]));
               vo = v_mem[it.index];
               prod = mo * longint'(cur_beta1) + g * longint'(q24 - cur_beta1);
               m = sat_s(scale_signed(prod, 1, 24), sat);
               v = vo * cur_beta2 + g2 * (q24 - cur_beta2);
               v = sat_u(rnd_shift(v, 24), sat);
            end
            m_mem[it.index] = m[31:0];
            v_mem[it.index] = v[31:0];
            s = v + cur_stab;
            if (s == 0) begin s = 1; sat = 1; end
            q = int_sqrt(s << 30);
            r = (64'd1 << 47) / q;
            d = rnd_shift((m < 0 ? longint'(-m) : m) * r, 24);
            d = rnd_shift(d * cur_step, 24);
            w = sat_s(m < 0 ? w + longint'(d) : w - longint'(d), sat);
         end
         if (cur_decay_en) w = sat_s(w - scale_signed(w, cur_decay, 24), sat);
         if (it.pass_end) past_first = 1;
      end
      o.out_index  = it.index;
      o.new_weight = w[31:0];
      o.saturated  = sat;
      return o;
   endfunction

   task automatic csr_write(logic [2:0] sel, logic [23:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      unique case (sel)
         CSR_MODE:       cur_mode = val[1:0];
         CSR_DECAY_EN:   cur_decay_en = val[0];
         CSR_DECAY_RATE: cur_decay = val;
         CSR_STEP:       cur_step = val;
         CSR_BETA1:      cur_beta1 = val;
         CSR_BETA2:      cur_beta2 = val;
         CSR_STAB:       cur_stab = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // offers one beat; the expectation is queued at the accepting edge
   task automatic send(req_type it, bit fixed, rsp_type want);
      int gap, k;
      rsp_type exp_r;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      exp_r = update_weight(it);
      pending_q.insert(pending_q.size(), fixed ? want : exp_r);
      k = $urandom_range(0, 99);
      gap = quiet ? 0 : (k < 60 ? 0 : k < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40));
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_val();
      unique case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         4: return 32'h0;
         default: return $urandom_range(0, 32'h10_0000) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   function automatic logic [23:0] pick_rate();
      unique case ($urandom_range(0, 3))
         0: return 24'h0;
         1: return 24'hFF_FFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      int k;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            stall = 400;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            k = $urandom_range(0, 99);
            if (!quiet) stall = k < 70 ? 0 : k < 95 ? $urandom_range(1, 3) : $urandom_range(10, 50);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) report("unexpected beat", 64'(rsp_data), 64'd0);
         else begin
            w = pending_q.pop_front();
            if (rsp_data.out_index !== w.out_index)
               report("out_index", 64'(rsp_data.out_index), 64'(w.out_index));
            if (rsp_data.new_weight !== w.new_weight)
               report("new_weight", 64'(rsp_data.new_weight), 64'(w.new_weight));
            if (rsp_data.saturated !== w.saturated)
               report("saturated", 64'(rsp_data.saturated), 64'(w.saturated));
         end
      end
   end

   initial begin
      step_row_type row;
      req_type it;
      logic [23:0] rate;
      mode_type phase_mode [8] = '{MODE_ADAM, MODE_GD, MODE_ADAM, MODE_NONE,
                                   MODE_ADAM, MODE_GD, MODE_ADAM, MODE_ADAM};
      cur_mode = MODE_NONE; cur_decay_en = 0; cur_decay = 0;
      cur_step = RST_STEP; cur_beta1 = RST_BETA1; cur_beta2 = RST_BETA2;
      cur_stab = RST_STAB; past_first = 0;
      foreach (m_mem[i]) begin m_mem[i] = 0; v_mem[i] = 0; end

      // directed: rows in idle modes carry expectations, the rest use the predictor
      add_beat('{12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0},
               1'b1, '{12'd0, 32'h7FFF_FFFF, 1'b0});
      add_beat('{12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1},
               1'b1, '{12'd4095, 32'h8000_0000, 1'b0});
      add_csr(CSR_MODE, 24'(MODE_SPARE));
      add_beat('{12'd3, 32'h0001_E240, 32'h0000_1000, 1'b1, 1'b1},
               1'b1, '{12'd3, 32'h0001_E240, 1'b0});
      add_csr(CSR_MODE, 24'(MODE_GD));
      add_csr(CSR_STEP, 24'hFF_FFFF);
      add_beat('{12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}, 1'b0, '0);
      add_beat('{12'd2, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '0);
      add_beat('{12'd2, 32'h0003_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}, 1'b0, '0);
      add_csr(CSR_DECAY_EN, 24'd1);
      add_csr(CSR_DECAY_RATE, 24'hFF_FFFF);
      add_beat('{12'd9, 32'h8000_0000, 32'h0, 1'b1, 1'b0}, 1'b0, '0);
      add_csr(CSR_MODE, 24'(MODE_ADAM));
      add_csr(CSR_DECAY_EN, 24'd0);
      add_csr(CSR_STAB, 24'd0);
      add_beat('{12'd5, 32'h0001_0000, 32'h0, 1'b1, 1'b0}, 1'b0, '0);
      add_beat('{12'd6, 32'h0001_0000, 32'h8000_0000, 1'b1, 1'b1}, 1'b0, '0);
      add_beat('{12'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '0);
      add_beat('{12'd7, 32'h0002_0000, 32'h1234_5678, 1'b0, 1'b0}, 1'b0, '0);
      add_csr(CSR_SPARE, 24'hFF_FFFF);
      add_csr(CSR_BETA1, 24'd0);
      add_csr(CSR_BETA2, 24'd0);
      add_beat('{12'd6, 32'h0000_8000, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, '0);
      add_csr(CSR_BETA1, 24'hFF_FFFF);
      add_csr(CSR_BETA2, 24'hFF_FFFF);
      add_beat('{12'd6, 32'hFFFF_0000, 32'h8000_0000, 1'b1, 1'b1}, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         row = rows[i];
         if (row.is_csr) begin
            drain();
            csr_write(row.csr_sel, row.csr_val);
         end else send(row.beat, row.fixed, row.want);
      end

      for (int p = 0; p < 8; p++) begin
         drain();
         csr_write(CSR_MODE, 24'(phase_mode[p]));
         csr_write(CSR_DECAY_EN, 24'($urandom_range(0, 1)));
         rate = $urandom_range(0, 1) ? 24'($urandom_range(0, 24'h2000)) : pick_rate();
         csr_write(CSR_DECAY_RATE, p == 0 ? 24'h0 : rate);
         csr_write(CSR_STEP, p == 1 ? 24'hFF_FFFF : pick_rate());
         csr_write(CSR_BETA1, p < 2 ? RST_BETA1 : pick_rate());
         csr_write(CSR_BETA2, p < 2 ? RST_BETA2 : pick_rate());
         csr_write(CSR_STAB, p == 2 ? 24'h0 :
                   (p == 4 ? 24'hFFFF : 24'($urandom_range(0, 24'hFFFF))));
         quiet = (p == 5);
         if (p == 2) hold_req = 1;
         repeat (110) begin
            it.index        = $urandom_range(0, 3) != 0 ? 12'($urandom_range(0, 15))
                                                       : 12'($urandom_range(0, 4095));
            it.weight       = pick_val();
            it.gradient     = pick_val();
            it.has_gradient = $urandom_range(0, 9) != 0;
            it.pass_end     = $urandom_range(0, 9) == 0;
            send(it, 1'b0, '0);
         end
         @(negedge clock);
         req_valid <= 1'b0;
      end

      drain();
      if (errors == 0 && pending_q.size() == 0)
         $display("adam_sgd_weight_update verification clean");
      else
         $display("adam_sgd_weight_update verification failed");
      $finish;
   end

endmodule
